/* src/txim_pkg.sv */
// Shared types and codes for the transmit-image mailbox.
// Used by tx_image_slot_mailbox_core; depends on nothing else.
package txim_pkg;

  typedef enum logic [1:0] {
    MODE_PUBLISH = 2'd0,
    MODE_ACQUIRE = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_STATUS  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OWN_INACTIVE = 2'd0,
    OWN_READY    = 2'd1,
    OWN_ACTIVE   = 2'd2
  } owner_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_EXEC  = 3'd1,
    ST_SCAN  = 3'd2,
    ST_CHECK = 3'd3,
    ST_READ  = 3'd4,
    ST_DONE  = 3'd5
  } state_t;

  // Slot count and payload capacity match the fixed port widths
  localparam int SLOT_COUNT       = 4;
  localparam int PAYLOAD_CAPACITY = 256;

  // Event counters, also the status select codes that read them
  localparam int          CNT_NUM       = 6;
  localparam logic [2:0]  CNT_PUBLISHED = 3'd0;
  localparam logic [2:0]  CNT_REJECTED  = 3'd1;
  localparam logic [2:0]  CNT_ACQUIRED  = 3'd2;
  localparam logic [2:0]  CNT_STALE     = 3'd3;
  localparam logic [2:0]  CNT_REUSED    = 3'd4;
  localparam logic [2:0]  CNT_RELEASED  = 3'd5;
  localparam logic [2:0]  SEL_ACT_SLOT  = 3'd6;
  localparam logic [2:0]  SEL_ACT_GEN   = 3'd7;

  localparam int DESC_SIZE_W = 9;

  typedef struct packed {
    logic [31:0]            gen;
    logic [31:0]            seq;
    logic [31:0]            segs;
    logic [DESC_SIZE_W-1:0] size;
  } desc_t;

endpackage

/* src/tx_image_slot_mailbox_core.sv */
// Transmit-image mailbox: slot ownership, ready ring, descriptor store, event counters.
// Depends on txim_pkg.
//
//   port group | direction | handshake         | contents
//   in_        | input     | in_valid/in_stall | mode, descriptor, status select
//   out_       | output    | out_valid/out_stall | ok, slot, descriptor, counts
//
// One word at a time. A word is taken only while the sequencer is idle; the result is
// registered through the states EXEC and DONE for release, status, a publish refused on its
// fields or a full ring and an acquire with nothing to hand out; EXEC, CHECK and DONE for an
// acquire whose ring entry is not ready; EXEC, CHECK, READ and DONE for any other acquire
// (ring read, owner check, descriptor read); EXEC, SCAN and DONE for a publish that scans,
// where the scan tests one owner entry per cycle. A finished result waits in the output
// register while the next word is taken. Reset (rst_n low, synchronous): all slots inactive,
// ring empty, no active slot, counters cleared. Descriptor and ring stores are not cleared.
module tx_image_slot_mailbox_core
  import txim_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_payload_size,
  input  logic [31:0] in_image_generation,
  input  logic [31:0] in_image_sequence,
  input  logic [31:0] in_segment_bits,
  input  logic [2:0]  in_status_select,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [1:0]  out_slot_number,
  output logic        out_stale_repeat,
  output logic [31:0] out_generation,
  output logic [31:0] out_sequence,
  output logic [31:0] out_segment_bits,
  output logic [8:0]  out_payload_size,
  output logic [2:0]  out_ready_count,
  output logic [31:0] out_status_value
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int AW = $clog2(SLOT_COUNT + 1);
  localparam int PW = $clog2(2 * SLOT_COUNT);
  localparam logic [AW-1:0] ACT_NONE = AW'(SLOT_COUNT);
  localparam logic [PW-1:0] PTR_LAST = PW'(2 * SLOT_COUNT - 1);
  localparam logic [PW-1:0] PTR_HALF = PW'(SLOT_COUNT);
  localparam logic [PW:0]   PTR_MOD  = (PW + 1)'(2 * SLOT_COUNT);
  localparam logic [PW:0]   Q_FULL   = (PW + 1)'(SLOT_COUNT);
  localparam logic [SW-1:0] IDX_LAST = SW'(SLOT_COUNT - 1);
  localparam logic [15:0]   CAP      = 16'(PAYLOAD_CAPACITY);

  state_t        state_r, state_nxt;
  mode_t         mode_r, mode_nxt;
  logic [15:0]   size_r, size_nxt;
  logic [31:0]   gen_r, gen_nxt;
  logic [31:0]   seq_r, seq_nxt;
  logic [31:0]   segs_r, segs_nxt;
  logic [2:0]    sel_r, sel_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic          reuse_r, reuse_nxt;
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [AW-1:0] act_r, act_nxt;
  logic [31:0]   act_gen_r, act_gen_nxt;
  logic [31:0]   cnt_r [CNT_NUM];
  logic [31:0]   cnt_nxt [CNT_NUM];
  logic [CNT_NUM-1:0] cnt_inc;
  owner_t        owner_r [SLOT_COUNT];
  owner_t        owner_nxt [SLOT_COUNT];

  logic          res_ok_r, res_ok_nxt;
  logic [SW-1:0] res_slot_r, res_slot_nxt;
  logic          res_reused_r, res_reused_nxt;
  desc_t         res_desc_r, res_desc_nxt;
  logic [31:0]   res_stat_r, res_stat_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_ok_r, out_ok_nxt;
  logic [1:0]    out_slot_r, out_slot_nxt;
  logic          out_reused_r, out_reused_nxt;
  desc_t         out_desc_r, out_desc_nxt;
  logic [2:0]    out_count_r, out_count_nxt;
  logic [31:0]   out_stat_r, out_stat_nxt;

  // Descriptor store and ready ring
  desc_t         dmem [SLOT_COUNT];
  desc_t         d_rd_r;
  logic          d_we;
  logic [SW-1:0] qmem [SLOT_COUNT];
  logic [SW-1:0] q_rd_r;
  logic          q_we;

  logic [PW:0]   queued;
  logic [SW-1:0] head_idx, tail_idx, act_idx;
  logic          act_valid;
  logic          out_free;

  always_comb begin
    if (head_r >= tail_r) begin
      queued = {1'b0, head_r} - {1'b0, tail_r};
    end else begin
      queued = {1'b0, head_r} + PTR_MOD - {1'b0, tail_r};
    end
    head_idx  = (head_r >= PTR_HALF) ? SW'(head_r - PTR_HALF) : SW'(head_r);
    tail_idx  = (tail_r >= PTR_HALF) ? SW'(tail_r - PTR_HALF) : SW'(tail_r);
    act_idx   = act_r[SW-1:0];
    act_valid = (act_r < ACT_NONE);
    out_free  = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dmem[idx_r] <= '{gen: gen_r, seq: seq_r, segs: segs_r, size: DESC_SIZE_W'(size_r)};
    end
    d_rd_r <= dmem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[head_idx] <= idx_r;
    end
    q_rd_r <= qmem[tail_idx];
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    size_nxt       = size_r;
    gen_nxt        = gen_r;
    seq_nxt        = seq_r;
    segs_nxt       = segs_r;
    sel_nxt        = sel_r;
    idx_nxt        = idx_r;
    reuse_nxt      = reuse_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    act_nxt        = act_r;
    act_gen_nxt    = act_gen_r;
    owner_nxt      = owner_r;
    cnt_inc        = '0;
    res_ok_nxt     = res_ok_r;
    res_slot_nxt   = res_slot_r;
    res_reused_nxt = res_reused_r;
    res_desc_nxt   = res_desc_r;
    res_stat_nxt   = res_stat_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_ok_nxt     = out_ok_r;
    out_slot_nxt   = out_slot_r;
    out_reused_nxt = out_reused_r;
    out_desc_nxt   = out_desc_r;
    out_count_nxt  = out_count_r;
    out_stat_nxt   = out_stat_r;
    d_we           = 1'b0;
    q_we           = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt       = mode_t'(in_mode);
          size_nxt       = in_payload_size;
          gen_nxt        = in_image_generation;
          seq_nxt        = in_image_sequence;
          segs_nxt       = in_segment_bits;
          sel_nxt        = in_status_select;
          idx_nxt        = '0;
          reuse_nxt      = 1'b0;
          res_ok_nxt     = 1'b0;
          res_slot_nxt   = '0;
          res_reused_nxt = 1'b0;
          res_desc_nxt   = '0;
          res_stat_nxt   = '0;
          state_nxt      = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (mode_r)
          MODE_PUBLISH: begin
            if (gen_r == 32'd0 || size_r > CAP || queued >= Q_FULL) begin
              cnt_inc[CNT_REJECTED] = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
          MODE_ACQUIRE: begin
            if (queued != '0) begin
              idx_nxt   = q_rd_r;
              state_nxt = ST_CHECK;
            end else if (!act_valid) begin
              state_nxt = ST_DONE;
            end else begin
              // ring empty: hand out the active image again
              cnt_inc[CNT_STALE]  = 1'b1;
              cnt_inc[CNT_REUSED] = 1'b1;
              res_reused_nxt = 1'b1;
              reuse_nxt      = 1'b1;
              idx_nxt        = act_idx;
              state_nxt      = ST_CHECK;
            end
          end
          MODE_RELEASE: begin
            if (act_valid) begin
              owner_nxt[act_idx]     = OWN_INACTIVE;
              act_nxt                = ACT_NONE;
              act_gen_nxt            = '0;
              cnt_inc[CNT_RELEASED]  = 1'b1;
              res_ok_nxt             = 1'b1;
            end
            state_nxt = ST_DONE;
          end
          MODE_STATUS: begin
            res_ok_nxt = 1'b1;
            if (sel_r == SEL_ACT_SLOT) begin
              res_stat_nxt = 32'(act_r);
            end else if (sel_r == SEL_ACT_GEN) begin
              res_stat_nxt = act_gen_r;
            end else begin
              res_stat_nxt = cnt_r[sel_r];
            end
            state_nxt = ST_DONE;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end

      ST_SCAN: begin
        if (owner_r[idx_r] == OWN_INACTIVE) begin
          d_we                   = 1'b1;
          q_we                   = 1'b1;
          owner_nxt[idx_r]       = OWN_READY;
          head_nxt               = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
          cnt_inc[CNT_PUBLISHED] = 1'b1;
          res_ok_nxt             = 1'b1;
          res_slot_nxt           = idx_r;
          state_nxt              = ST_DONE;
        end else if (idx_r == IDX_LAST) begin
          cnt_inc[CNT_REJECTED] = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_CHECK: begin
        if (reuse_r) begin
          state_nxt = ST_READ;
        end else if (owner_r[idx_r] != OWN_READY) begin
          cnt_inc[CNT_REJECTED] = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          // drop the previous image, then take the queued one
          if (act_valid) begin
            owner_nxt[act_idx]    = OWN_INACTIVE;
            cnt_inc[CNT_RELEASED] = 1'b1;
          end
          owner_nxt[idx_r]      = OWN_ACTIVE;
          tail_nxt              = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
          act_nxt               = AW'(idx_r);
          cnt_inc[CNT_ACQUIRED] = 1'b1;
          state_nxt             = ST_READ;
        end
      end

      ST_READ: begin
        res_ok_nxt   = 1'b1;
        res_slot_nxt = idx_r;
        res_desc_nxt = d_rd_r;
        act_gen_nxt  = d_rd_r.gen;
        state_nxt    = ST_DONE;
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_ok_nxt     = res_ok_r;
          out_slot_nxt   = 2'(res_slot_r);
          out_reused_nxt = res_reused_r;
          out_desc_nxt   = res_desc_r;
          out_count_nxt  = 3'(queued);
          out_stat_nxt   = res_stat_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    for (int k = 0; k < CNT_NUM; k++) begin
      cnt_nxt[k] = cnt_inc[k] ? cnt_r[k] + 32'd1 : cnt_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      act_r       <= ACT_NONE;
      act_gen_r   <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < CNT_NUM; k++) begin
        cnt_r[k] <= '0;
      end
      for (int s = 0; s < SLOT_COUNT; s++) begin
        owner_r[s] <= OWN_INACTIVE;
      end
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      act_r       <= act_nxt;
      act_gen_r   <= act_gen_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      owner_r     <= owner_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    size_r       <= size_nxt;
    gen_r        <= gen_nxt;
    seq_r        <= seq_nxt;
    segs_r       <= segs_nxt;
    sel_r        <= sel_nxt;
    idx_r        <= idx_nxt;
    reuse_r      <= reuse_nxt;
    res_ok_r     <= res_ok_nxt;
    res_slot_r   <= res_slot_nxt;
    res_reused_r <= res_reused_nxt;
    res_desc_r   <= res_desc_nxt;
    res_stat_r   <= res_stat_nxt;
    out_ok_r     <= out_ok_nxt;
    out_slot_r   <= out_slot_nxt;
    out_reused_r <= out_reused_nxt;
    out_desc_r   <= out_desc_nxt;
    out_count_r  <= out_count_nxt;
    out_stat_r   <= out_stat_nxt;
  end

  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_ok              = out_ok_r;
  assign out_slot_number     = out_slot_r;
  assign out_stale_repeat    = out_reused_r;
  assign out_generation      = out_desc_r.gen;
  assign out_sequence        = out_desc_r.seq;
  assign out_segment_bits    = out_desc_r.segs;
  assign out_payload_size    = out_desc_r.size;
  assign out_ready_count     = out_count_r;
  assign out_status_value    = out_stat_r;

`ifndef SYNTHESIS
  a_active_owned: assert property (@(posedge clk) disable iff (!rst_n)
    act_valid |-> owner_r[act_idx] == OWN_ACTIVE)
    else $error("active slot is not marked active");

  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    queued <= Q_FULL)
    else $error("ready ring holds more entries than slots");

  a_scan_publish: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> mode_r == MODE_PUBLISH)
    else $error("slot scan outside a publish");

  a_reuse_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stale_repeat |-> out_ok && out_ready_count == 3'd0)
    else $error("reused image reported without success or with ring not empty");
`endif

endmodule
